### rtl/stc_pkg.sv
package stc_pkg;

   // Group size and fixed scan constants
   localparam int unsigned FRAMES_PER_READ     = 10;
   localparam int unsigned FIRST_INDEX         = 'hA0;
   localparam longint unsigned US_PER_MINUTE   = 60000000;
   localparam int unsigned FRAMES_PER_ROTATION = 90;
   localparam int unsigned SPEED_ONE           = 64;

   // Field widths
   localparam int TIME_W  = 64;
   localparam int INDEX_W = 8;
   localparam int SPEED_W = 16;
   localparam int DIST_W  = 14;
   localparam int ANGLE_W = 16;
   localparam int SUM_W   = 20;
   localparam int COUNT_W = 4;
   localparam int POS_W   = 4;

   // Group timespan numerator and divider sizing
   localparam longint unsigned SPAN_NUM_VAL =
      US_PER_MINUTE * FRAMES_PER_READ * SPEED_ONE;
   localparam int NUM_W = $clog2(SPAN_NUM_VAL + 1);
   localparam int DVS_W = $clog2(((1 << SPEED_W) - 1) * FRAMES_PER_ROTATION + 1);
   localparam logic [NUM_W-1:0] SPAN_NUM = NUM_W'(SPAN_NUM_VAL);

   localparam int AVG_STEPS  = SUM_W;
   localparam int SPAN_STEPS = NUM_W;
   localparam int STEP_W     = $clog2(SPAN_STEPS);

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_FAIL   = 1'b1;

   localparam logic [DIST_W-1:0] CRC_FAIL_RESET = DIST_W'(102);

   // Bus widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 160;
   localparam int RSP_USER_W = 2;

endpackage

### rtl/scan_timestamp_corrector_unit.sv
// Timestamp corrector for a rotating range scanner. Frames come in on req_ one at a time and are
// grouped FRAMES_PER_READ to a group; the first frame of a group fixes the start angle
// ((index - 0xA0) * 4, 16-bit wrap), and each frame that is not a CRC-failed reading
// (invalid flag set and first distance equal to the crc_fail_distance register) adds its speed
// to a running sum. On the last frame of a group the block forms the average speed and the
// group timespan 60000000 * FRAMES_PER_READ * 64 / (90 * avg_speed) microseconds, then
// either adopts measured_time as the new reference or advances the reference by the timespan
// and reports the correction; one result transaction per group comes out on rsp_. With no
// sane frame or a zero average it reports a fault and keeps the reference. A frame that is
// not the last of its group leaves the block idle, ready for the next frame. The last frame
// holds the input off while the group's average and timespan are worked out on a single
// restoring divider that produces one quotient bit per cycle and is used twice: 20 steps for
// the average speed and 36 steps for the timespan. A finished result sits in an output
// register, so the next frames are taken while it waits for rsp_tready; a group that finishes
// while the previous result still waits holds the input off until rsp_tready frees that
// register. Writing start_time (register 0) also loads the running reference at once; write
// registers only while idle.
module scan_timestamp_corrector_unit
   import stc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_index, frame_speed, first_distance, measured_time, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // invalid_flag
   input  logic                  req_tuser,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // packet_time, avg_speed, start_angle, correction
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // took_measured, fault
   output logic [RSP_USER_W-1:0] rsp_tuser,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_AVG,
      S_MUL,
      S_DIV_SPAN,
      S_CMP,
      S_DEC,
      S_CORR,
      S_OUT
   } state_type;

   // request fields
   logic [INDEX_W-1:0] req_index;
   logic [SPEED_W-1:0] req_speed;
   logic [DIST_W-1:0]  req_dist;
   logic [TIME_W-1:0]  req_time;

   assign req_index = req_tdata[7:0];
   assign req_speed = req_tdata[23:8];
   assign req_dist  = req_tdata[37:24];
   assign req_time  = req_tdata[101:38];

   // state and registers
   state_type          state_ff,   state_in;
   logic [TIME_W-1:0]  ref_ff,     ref_in;
   logic [DIST_W-1:0]  crc_ff,     crc_in;
   logic [SUM_W-1:0]   sum_ff,     sum_in;
   logic [COUNT_W-1:0] cnt_ff,     cnt_in;
   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic [ANGLE_W-1:0] angle_ff,   angle_in;
   logic [TIME_W-1:0]  meas_ff,    meas_in;
   logic [SPEED_W-1:0] avg_ff,     avg_in;
   logic [TIME_W-1:0]  diff_ff,    diff_in;
   logic [TIME_W-1:0]  pkt_ff,     pkt_in;
   logic [TIME_W-1:0]  corr_ff,    corr_in;
   logic               took_ff,    took_in;
   logic               fault_ff,   fault_in;
   // shared divider
   logic [NUM_W-1:0]   div_n_ff,   div_n_in;
   logic [DVS_W-1:0]   div_d_ff,   div_d_in;
   logic [DVS_W-1:0]   div_r_ff,   div_r_in;
   logic [STEP_W-1:0]  step_ff,    step_in;
   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff,  rsp_user_in;

   // one restoring divide step: shift in the next dividend bit, try to subtract
   logic [DVS_W:0]     div_trial;
   logic [DVS_W+1:0]   div_sub;
   logic               div_ge;
   logic [DVS_W-1:0]   div_r_step;
   logic [NUM_W-1:0]   div_n_step;

   assign div_trial  = {div_r_ff, div_n_ff[NUM_W-1]};
   assign div_sub    = {1'b0, div_trial} - {2'b00, div_d_ff};
   assign div_ge     = ~div_sub[DVS_W+1];
   assign div_r_step = div_ge ? div_sub[DVS_W-1:0] : div_trial[DVS_W-1:0];
   assign div_n_step = {div_n_ff[NUM_W-2:0], div_ge};

   // frame bookkeeping
   logic               req_fire;
   logic               sane;
   logic [SUM_W-1:0]   sum_new;
   logic [COUNT_W-1:0] cnt_new;
   logic               last_frame;
   logic [ANGLE_W-1:0] angle_new;
   logic [SPEED_W-1:0] avg_q;
   logic [TIME_W-1:0]  span;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign sane       = ~(req_tuser & (req_dist == crc_ff));
   assign sum_new    = sane ? sum_ff + SUM_W'(req_speed) : sum_ff;
   assign cnt_new    = sane ? cnt_ff + COUNT_W'(1) : cnt_ff;
   assign last_frame = ({1'b0, pos_ff} + (POS_W+1)'(1)) >= (POS_W+1)'(FRAMES_PER_READ);
   assign angle_new  = ({{(ANGLE_W-INDEX_W){1'b0}}, req_index} - ANGLE_W'(FIRST_INDEX)) << 2;
   assign avg_q      = div_n_ff[SPEED_W-1:0];
   assign span       = TIME_W'(div_n_ff);

   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      crc_in       = crc_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      angle_in     = angle_ff;
      meas_in      = meas_ff;
      avg_in       = avg_ff;
      diff_in      = diff_ff;
      pkt_in       = pkt_ff;
      corr_in      = corr_ff;
      took_in      = took_ff;
      fault_in     = fault_ff;
      div_n_in     = div_n_ff;
      div_d_in     = div_d_ff;
      div_r_in     = div_r_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // group angle comes from the first frame only
               if (pos_ff == '0) begin
                  angle_in = angle_new;
               end
               if (last_frame) begin
                  meas_in = req_time;
                  pos_in  = '0;
                  sum_in  = '0;
                  cnt_in  = '0;
                  if (cnt_new == '0) begin
                     // nothing sane in the group: report a fault, keep reference
                     avg_in   = '0;
                     pkt_in   = ref_ff;
                     corr_in  = '0;
                     took_in  = 1'b0;
                     fault_in = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     // average speed = sum / count, dividend top-aligned
                     div_n_in = {sum_new, {(NUM_W-SUM_W){1'b0}}};
                     div_d_in = DVS_W'(cnt_new);
                     div_r_in = '0;
                     step_in  = STEP_W'(AVG_STEPS - 1);
                     state_in = S_DIV_AVG;
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
                  sum_in = sum_new;
                  cnt_in = cnt_new;
               end
            end
         end

         S_DIV_AVG: begin
            div_n_in = div_n_step;
            div_r_in = div_r_step;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            avg_in = avg_q;
            if (avg_q == '0) begin
               pkt_in   = ref_ff;
               corr_in  = '0;
               took_in  = 1'b0;
               fault_in = 1'b1;
               state_in = S_OUT;
            end else begin
               // timespan = NUM / (90 * avg)
               div_n_in = SPAN_NUM;
               div_d_in = DVS_W'(avg_q) * DVS_W'(FRAMES_PER_ROTATION);
               div_r_in = '0;
               step_in  = STEP_W'(SPAN_STEPS - 1);
               state_in = S_DIV_SPAN;
            end
         end

         S_DIV_SPAN: begin
            div_n_in = div_n_step;
            div_r_in = div_r_step;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            diff_in = meas_ff - span;
            state_in = S_DEC;
         end

         S_DEC: begin
            fault_in = 1'b0;
            if (diff_ff < ref_ff) begin
               // measured time lands behind the reference: adopt it
               ref_in   = meas_ff;
               pkt_in   = diff_ff;
               corr_in  = '0;
               took_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               // advance the reference by one timespan
               pkt_in   = ref_ff;
               ref_in   = ref_ff + span;
               took_in  = 1'b0;
               state_in = S_CORR;
            end
         end

         S_CORR: begin
            corr_in  = meas_ff - ref_ff;
            state_in = S_OUT;
         end

         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {corr_ff, angle_ff, avg_ff, pkt_ff};
               rsp_user_in  = {fault_ff, took_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // the user must issue register writes only while idle; this block has no check for it
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_TIME: ref_in = csr_wdata;
            CSR_CRC_FAIL:   crc_in = csr_wdata[DIST_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_ff       <= '0;
         crc_ff       <= CRC_FAIL_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         angle_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         crc_ff       <= crc_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         angle_ff     <= angle_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      meas_ff     <= meas_in;
      avg_ff      <= avg_in;
      diff_ff     <= diff_in;
      pkt_ff      <= pkt_in;
      corr_ff     <= corr_in;
      took_ff     <= took_in;
      fault_ff    <= fault_in;
      div_n_ff    <= div_n_in;
      div_d_ff    <= div_d_in;
      div_r_ff    <= div_r_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // the divider remainder always stays below the divisor while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_AVG || state_ff == S_DIV_SPAN) |-> (div_r_ff < div_d_ff))
      else $error("divider remainder out of range");

   // a fault result never adopts the measured time and carries no correction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1]) |-> (!rsp_user_ff[0] && rsp_data_ff[159:96] == '0))
      else $error("fault result with correction or adopted time");

   // the frame position never reaches the group size
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} < (POS_W+1)'(FRAMES_PER_READ)))
      else $error("frame position past group end");

   // a new result is loaded only from the output state
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_OUT))
      else $error("result loaded outside output state");

endmodule

### verif/scan_timestamp_corrector_unit_tb.sv
module scan_timestamp_corrector_unit_tb;
   import stc_pkg::*;

   // Cycles with no transaction on either side before the run is declared hung.
   // The worst correct stretch is the long receiver hold below plus one group's
   // divider time and a sender gap, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT  = 20000;
   // Quiet cycles before a register write and at the end: covers the divider run
   // on a group's last frame with room to spare.
   localparam int IDLE_SETTLE     = 100;
   // Long receiver hold: long enough for two groups to finish and back up the input.
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int HOLD_AFTER      = 30;

   localparam logic [63:0] SPAN_NUMERATOR =
      64'(US_PER_MINUTE) * 64'(FRAMES_PER_READ) * 64'(SPEED_ONE);

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [SPEED_W-1:0] speed;
      logic               invalid;
      logic [DIST_W-1:0]  distance;
      logic [TIME_W-1:0]  measured;
   } frame_type;

   typedef struct packed {
      logic [TIME_W-1:0]  packet_time;
      logic [SPEED_W-1:0] avg_speed;
      logic [ANGLE_W-1:0] start_angle;
      logic [TIME_W-1:0]  correction;
      logic               took_measured;
      logic               fault;
   } stamp_result_type;

   // One frame to offer; a typed row carries its own expected group result.
   typedef struct packed {
      frame_type        f;
      logic             typed;
      stamp_result_type r;
   } stim_row_type;

   typedef enum {GRP_NORMAL, GRP_ALL_CRC_FAIL, GRP_ZERO_SPEED} group_kind_type;
   typedef enum {MT_NEAR_AHEAD, MT_NEAR_BEHIND, MT_ANY} measured_mode_type;
   typedef enum {RX_OPEN, RX_SPARSE, RX_RANDOM} rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [TIME_W-1:0]     csr_wdata  = '0;

   // Scan model state, mirrors what the block keeps between frames
   logic [TIME_W-1:0]  ref_stamp     = '0;
   logic [DIST_W-1:0]  crc_code      = CRC_FAIL_RESET;
   logic [SUM_W-1:0]   speed_total   = '0;
   logic [COUNT_W-1:0] sane_total    = '0;
   logic [POS_W-1:0]   slot          = '0;
   logic [ANGLE_W-1:0] latched_angle = '0;

   stamp_result_type pending_stamps[$];
   stim_row_type     offered_frames[$];
   stim_row_type     directed_rows[$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;

   scan_timestamp_corrector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the scan model by one accepted frame. Returns 1 when the frame
   // closes a group, with the group result in stamp.
   function automatic bit advance_scan_model(input frame_type f,
                                             output stamp_result_type stamp);
      logic [ANGLE_W-1:0] offset;
      logic [SPEED_W-1:0] avg;
      logic [TIME_W-1:0]  span;
      logic [TIME_W-1:0]  early;
      stamp = '0;
      // First frame of a group latches the angle and clears the accumulators
      if (slot == 0) begin
         offset        = {8'd0, f.index} - ANGLE_W'(FIRST_INDEX);
         latched_angle = offset << 2;
         speed_total   = '0;
         sane_total    = '0;
      end
      // A CRC-failed reading contributes nothing to the speed average
      if (!(f.invalid && f.distance == crc_code)) begin
         speed_total = speed_total + f.speed;
         sane_total  = sane_total + 1'b1;
      end
      if (slot + 1 < FRAMES_PER_READ) begin
         slot = slot + 1'b1;
         return 1'b0;
      end
      avg = (sane_total != 0) ? SPEED_W'(speed_total / sane_total) : '0;
      stamp.packet_time = ref_stamp;
      stamp.avg_speed   = avg;
      stamp.start_angle = latched_angle;
      if (avg == 0) begin
         // No usable speed: flag it and keep the reference where it is
         stamp.fault = 1'b1;
      end else begin
         span  = SPAN_NUMERATOR / (64'(FRAMES_PER_ROTATION) * 64'(avg));
         early = f.measured - span;
         if (early < ref_stamp) begin
            // Measured time lags the reference: adopt it
            ref_stamp           = f.measured;
            stamp.packet_time   = early;
            stamp.took_measured = 1'b1;
         end else begin
            ref_stamp        = ref_stamp + span;
            stamp.correction = f.measured - ref_stamp;
         end
      end
      slot        = '0;
      speed_total = '0;
      sane_total  = '0;
      return 1'b1;
   endfunction

   function automatic frame_type frm(input logic [7:0] index, input logic [15:0] speed,
                                     input logic invalid, input logic [13:0] distance,
                                     input logic [63:0] measured);
      frame_type f;
      f.index    = index;
      f.speed    = speed;
      f.invalid  = invalid;
      f.distance = distance;
      f.measured = measured;
      return f;
   endfunction

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // Offer one frame and hold it until the block takes it. Between bursts,
   // drop tvalid for a random gap; inside a burst keep it high.
   task automatic offer(input stim_row_type row);
      offered_frames.push_back(row);
      // fields from bit 0 up: frame_index, frame_speed, first_distance, measured_time
      req_tdata  <= {2'b00, row.f.measured, row.f.distance, row.f.speed, row.f.index};
      req_tuser  <= row.f.invalid;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // Let every expected group result drain, then give the divider time to settle.
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_stamps.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      // A start_time write reloads the running reference too
      if (idx == CSR_START_TIME) begin
         ref_stamp = value;
      end else begin
         crc_code = value[DIST_W-1:0];
      end
      @(posedge clock);
   endtask

   // One group of FRAMES_PER_READ frames. Most groups look like a real rotation:
   // consecutive indexes, speeds around a common value, a few CRC-failed
   // readings, and a measured time near where the reference is heading.
   task automatic send_random_group();
      stim_row_type      row;
      group_kind_type    kind;
      measured_mode_type mm;
      logic [7:0]        first_index;
      logic [15:0]       base_speed;
      int                pick;
      int                k;
      pick = $urandom_range(0, 19);
      kind = GRP_NORMAL;
      if (pick == 0) kind = GRP_ALL_CRC_FAIL;
      else if (pick == 1) kind = GRP_ZERO_SPEED;
      first_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(8'hA0, 8'hF9));
      base_speed  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(15000, 25000));
      for (k = 0; k < FRAMES_PER_READ; k++) begin
         row          = '0;
         row.f.index  = first_index + 8'(k);
         if (kind == GRP_ZERO_SPEED)
            row.f.speed = '0;
         else if ($urandom_range(0, 9) == 0)
            row.f.speed = 16'($urandom_range(0, 65535));
         else
            row.f.speed = base_speed + 16'($urandom_range(0, 200));
         if (kind == GRP_ALL_CRC_FAIL || $urandom_range(0, 7) == 0) begin
            row.f.invalid  = 1'b1;
            row.f.distance = crc_code;
         end else begin
            row.f.invalid  = 1'($urandom_range(0, 1));
            row.f.distance = 14'($urandom_range(0, 16383));
         end
         row.f.measured = {$urandom, $urandom};
         if (k == FRAMES_PER_READ - 1) begin
            pick = $urandom_range(0, 9);
            mm   = (pick < 6) ? MT_NEAR_AHEAD : (pick < 8) ? MT_NEAR_BEHIND : MT_ANY;
            case (mm)
               MT_NEAR_AHEAD:  row.f.measured = ref_stamp + 64'($urandom_range(0, 60000));
               MT_NEAR_BEHIND: row.f.measured = ref_stamp - 64'($urandom_range(0, 60000));
               default:        row.f.measured = {$urandom, $urandom};
            endcase
         end
         offer(row);
      end
   endtask

   task automatic run_phase(input logic [63:0] start, input logic [13:0] crc,
                            input int groups);
      wait_block_idle();
      write_csr(CSR_START_TIME, start);
      write_csr(CSR_CRC_FAIL, 64'(crc));
      repeat (groups) send_random_group();
   endtask

   // Input monitor: feed every accepted frame through the model
   always @(posedge clock) begin : req_monitor
      stim_row_type     row;
      frame_type        f;
      stamp_result_type stamp;
      if (!reset && req_tvalid && req_tready) begin
         row        = offered_frames.pop_front();
         f.index    = req_tdata[7:0];
         f.speed    = req_tdata[23:8];
         f.distance = req_tdata[37:24];
         f.measured = req_tdata[101:38];
         f.invalid  = req_tuser;
         if (advance_scan_model(f, stamp))
            pending_stamps.push_back(row.typed ? row.r : stamp);
      end
   end

   // Result monitor: compare each group result with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      stamp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_stamps.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0h/%0h",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_stamps.pop_front();
            check_field("packet_time", want.packet_time, rsp_tdata[63:0]);
            check_field("avg_speed", 64'(want.avg_speed), 64'(rsp_tdata[79:64]));
            check_field("start_angle", 64'(want.start_angle), 64'(rsp_tdata[95:80]));
            check_field("correction", want.correction, rsp_tdata[159:96]);
            check_field("took_measured", 64'(want.took_measured), 64'(rsp_tuser[0]));
            check_field("fault", 64'(want.fault), 64'(rsp_tuser[1]));
         end
      end
   end

   // Watchdog: count cycles with no transaction on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Receiver pacing: stretches of always-ready, a sparse fixed pattern and
   // coin flips. Once enough results have come, hold off for a long stretch so
   // the output register fills and the block stops taking frames.
   initial begin : rsp_pacer
      rx_mode_type mode;
      int          stretch;
      int          n;
      bit          hold_done;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         mode    = rx_mode_type'($urandom_range(0, 2));
         stretch = $urandom_range(40, 400);
         for (n = 0; n < stretch; n++) begin
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_SPARSE: rsp_tready <= (n % 5 == 4);
               default:   rsp_tready <= 1'($urandom_range(0, 1));
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      // Directed groups, run on reset register values (start 0, CRC code 102).
      // All CRC-failed frames: nothing sane, so a fault with the reference kept.
      // Index 0x00 wraps the angle below the first index.
      directed_rows.push_back('{frm(8'h00, 16'hFFFF, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h01, 16'h0000, 1'b1, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h02, 16'h8000, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h03, 16'h0001, 1'b1, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h04, 16'h7FFF, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h05, 16'hFFFF, 1'b1, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h06, 16'hFFFF, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h07, 16'hFFFF, 1'b1, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h08, 16'hFFFF, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h09, 16'hFFFF, 1'b1, 14'd102, '1), 1'b1,
                                '{64'd0, 16'd0, 16'hFD80, 64'd0, 1'b0, 1'b1}});
      // Sane frames at zero speed, one CRC-failed frame at full speed that must
      // not count: average zero, so a fault. Index 0xFF gives angle 380.
      directed_rows.push_back('{frm(8'hFF, 16'h0000, 1'b0, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h00, 16'h0000, 1'b1, 14'h3FFF, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h01, 16'hFFFF, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h02, 16'h0000, 1'b1, 14'd101, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h03, 16'h0000, 1'b0, 14'd0, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h04, 16'h0000, 1'b0, 14'h3FFF, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h05, 16'h0000, 1'b1, 14'd0, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h06, 16'h0000, 1'b0, 14'd102, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'h07, 16'h0000, 1'b1, 14'd103, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h08, 16'h0000, 1'b0, 14'd1, '1), 1'b1,
                                '{64'd0, 16'd0, 16'h017C, 64'd0, 1'b0, 1'b1}});
      // Top speed with one CRC-failed slow frame; index 0xA0 gives angle 0 and
      // a measured time at the top of its range advances the reference.
      directed_rows.push_back('{frm(8'hA0, 16'hFFFF, 1'b0, 14'd0, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA1, 16'hFFFF, 1'b0, 14'h3FFF, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA2, 16'h0001, 1'b1, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'h9F, 16'hFFFF, 1'b1, 14'd0, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA4, 16'hFFFF, 1'b0, 14'd102, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA5, 16'hFFFF, 1'b1, 14'h3FFF, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA6, 16'hFFFF, 1'b0, 14'd5, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA7, 16'hFFFF, 1'b0, 14'd6, '1), 1'b0, '0});
      directed_rows.push_back('{frm(8'hA8, 16'hFFFF, 1'b0, 14'd7, 64'd0), 1'b0, '0});
      directed_rows.push_back('{frm(8'hFF, 16'hFFFF, 1'b0, 14'd8, '1), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i]);

      // Random phases, each on its own register setting, extremes first
      run_phase('1, 14'd0, 50);
      run_phase(64'd0, 14'h3FFF, 40);
      run_phase({$urandom, $urandom}, 14'd102, 45);
      run_phase(64'($urandom), 14'($urandom_range(0, 16383)), 45);

      wait_block_idle();
      if (mismatch_count == 0 && pending_stamps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/stc_pkg.sv
rtl/scan_timestamp_corrector_unit.sv
verif/scan_timestamp_corrector_unit_tb.sv
